// ----- rtl/rls_pkg.sv -----
package rls_pkg;

  localparam int unsigned MaxLeds    = 256;
  localparam int unsigned BitsPerLed = 24;
  localparam int unsigned LedAw      = $clog2(MaxLeds);
  localparam int unsigned BitCntW    = 5;

  localparam logic [BitCntW-1:0] BitLast = BitCntW'(BitsPerLed - 1);

  // action codes
  localparam logic [1:0] ActSet   = 2'd0;
  localparam logic [1:0] ActStart = 2'd1;
  localparam logic [1:0] ActTick  = 2'd2;

  // configuration register indexes
  localparam logic RegLedCount = 1'b0;

  typedef enum logic {
    ST_IDLE,
    ST_LOAD
  } ctrl_state_e;

  typedef struct packed {
    logic                  we;
    logic [LedAw-1:0]      waddr;
    logic [BitsPerLed-1:0] wdata;
    logic                  re;
    logic [LedAw-1:0]      raddr;
  } mem_req_t;

  typedef struct packed {
    logic valid;
    logic data_out;
    logic clock_out;
    logic busy_res;
    logic accepted;
  } result_t;

endpackage

// ----- rtl/rls_store.sv -----
module rls_store
  import rls_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mem_req_t              req_i,
  output logic [BitsPerLed-1:0] rdata_o
);

  logic [BitsPerLed-1:0] mem_q [MaxLeds];
  logic [MaxLeds-1:0]    vld_q;
  logic [BitsPerLed-1:0] rdata_q;
  logic                  rvld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  // per-entry valid bits stand in for clearing the store at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rvld_q <= vld_q[req_i.raddr];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

// ----- rtl/rls_ctrl.sv -----
module rls_ctrl
  import rls_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [1:0]            action_i,
  input  logic [LedAw-1:0]      led_index_i,
  input  logic [BitsPerLed-1:0] color_i,
  input  logic [LedAw-1:0]      led_count_i,
  input  logic [BitsPerLed-1:0] mem_rdata_i,
  output mem_req_t              mem_req_o,
  output logic                  busy_o,
  output result_t               res_o
);

  ctrl_state_e           state_q, state_d;
  logic                  shifting_q, shifting_d;
  logic [LedAw-1:0]      cur_q, cur_d;
  logic [BitCntW-1:0]    bc_q, bc_d;
  logic                  phase_q, phase_d;
  logic [BitsPerLed-1:0] sw_q, sw_d;
  result_t               res_q, res_d;
  result_t               pend_q, pend_d;
  logic [LedAw:0]        next_led;

  assign next_led = {1'b0, cur_q} + (LedAw+1)'(1);

  always_comb begin
    state_d    = state_q;
    shifting_d = shifting_q;
    cur_d      = cur_q;
    bc_d       = bc_q;
    phase_d    = phase_q;
    sw_d       = sw_q;
    pend_d     = pend_q;
    res_d      = '0;
    mem_req_o  = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept_i) begin
          res_d.valid    = 1'b1;
          res_d.busy_res = shifting_q;
          if (shifting_q) begin
            if (action_i == ActTick) begin
              res_d.data_out = sw_q[BitsPerLed-1];
              if (!phase_q) begin
                phase_d = 1'b1;
              end else begin
                res_d.clock_out = 1'b1;
                phase_d = 1'b0;
                sw_d    = {sw_q[BitsPerLed-2:0], 1'b0};
                if (bc_q == BitLast) begin
                  bc_d = '0;
                  if (next_led < {1'b0, led_count_i}) begin
                    // fetch the next led, result goes out with the load
                    cur_d           = next_led[LedAw-1:0];
                    mem_req_o.re    = 1'b1;
                    mem_req_o.raddr = next_led[LedAw-1:0];
                    pend_d          = res_d;
                    res_d.valid     = 1'b0;
                    state_d         = ST_LOAD;
                  end else begin
                    shifting_d     = 1'b0;
                    cur_d          = '0;
                    sw_d           = '0;
                    res_d.busy_res = 1'b0;
                  end
                end else begin
                  bc_d = bc_q + BitCntW'(1);
                end
              end
            end
          end else begin
            unique case (action_i)
              ActSet: begin
                if (led_index_i < led_count_i) begin
                  mem_req_o.we    = 1'b1;
                  mem_req_o.waddr = led_index_i;
                  mem_req_o.wdata = color_i;
                  res_d.accepted  = 1'b1;
                end
              end
              ActStart: begin
                res_d.accepted = 1'b1;
                cur_d   = '0;
                bc_d    = '0;
                phase_d = 1'b0;
                if (led_count_i != '0) begin
                  shifting_d      = 1'b1;
                  res_d.busy_res  = 1'b1;
                  mem_req_o.re    = 1'b1;
                  mem_req_o.raddr = '0;
                  pend_d          = res_d;
                  res_d.valid     = 1'b0;
                  state_d         = ST_LOAD;
                end else begin
                  sw_d = '0;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      ST_LOAD: begin
        sw_d        = mem_rdata_i;
        res_d       = pend_q;
        res_d.valid = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      shifting_q <= 1'b0;
      cur_q      <= '0;
      bc_q       <= '0;
      phase_q    <= 1'b0;
      sw_q       <= '0;
      res_q      <= '0;
    end else begin
      state_q    <= state_d;
      shifting_q <= shifting_d;
      cur_q      <= cur_d;
      bc_q       <= bc_d;
      phase_q    <= phase_d;
      sw_q       <= sw_d;
      res_q      <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

  assign busy_o = (state_q == ST_LOAD);
  assign res_o  = res_q;

endmodule

// ----- rtl/rgb_led_strip_shift_out.sv -----
// results: an item's result is registered and strobed in the cycle after it is taken;
// a start that goes busy and the tick that moves on to the next led (one store read
// each) hold it in a pending register through the load state before it is strobed
// throughput: 1 item per cycle unless busy in the load state (single store read port)
// reset: control cleared at once, the pixel store reads as zero through per-led
// valid bits, no clearing pass; the receiver cannot stall
module rgb_led_strip_shift_out
  import rls_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            action_i,
  input  logic [LedAw-1:0]      led_index_i,
  input  logic [BitsPerLed-1:0] color_i,
  output logic                  valid_o,
  output logic                  data_out_o,
  output logic                  clock_out_o,
  output logic                  busy_res_o,
  output logic                  accepted_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [LedAw-1:0]      led_count_q;
  mem_req_t              mem_req;
  logic [BitsPerLed-1:0] mem_rdata;
  result_t               res;
  logic                  accept;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_count_q <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == RegLedCount)) begin
      led_count_q <= pwdata[LedAw-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegLedCount) begin
      prdata = {{(32-LedAw){1'b0}}, led_count_q};
    end
  end

  assign accept = start && !busy;

  rls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .action_i    (action_i),
    .led_index_i (led_index_i),
    .color_i     (color_i),
    .led_count_i (led_count_q),
    .mem_rdata_i (mem_rdata),
    .mem_req_o   (mem_req),
    .busy_o      (busy),
    .res_o       (res)
  );

  rls_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign valid_o     = res.valid;
  assign data_out_o  = res.data_out;
  assign clock_out_o = res.clock_out;
  assign busy_res_o  = res.busy_res;
  assign accepted_o  = res.accepted;

endmodule
